// ----- rtl/core/osenm_pkg.sv -----
// ----------------------------------------------------------------------------
// osenm_pkg: shared definitions for the ordered store with nearest-min extract
// Widths, codes, the microcode word format and the control program itself.
// ----------------------------------------------------------------------------
package osenm_pkg;

  // Store geometry.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // Transaction fields.
  localparam int VALUE_W  = 32;
  localparam int REF_W    = 7;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int DIST_W   = (IDX_W > REF_W) ? IDX_W : REF_W;

  localparam int IN_BITS     = VALUE_W + 1 + REF_W;
  localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + FOUND_W;
  localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Request kinds carried in tuser.
  localparam logic REQ_APPEND  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_APPEND,
    OP_SET_EMPTY,
    OP_SCAN_INIT,
    OP_SCAN_FIRST,
    OP_SCAN,
    OP_SHIFT_INIT,
    OP_SHIFT,
    OP_EXTRACT_DONE,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_APPEND,
    C_EMPTY,
    C_SINGLE,
    C_SCAN_MORE,
    C_SHIFT_NONE,
    C_SHIFT_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 4;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Status the datapath reports to the sequencer.
  typedef struct packed {
    logic               in_valid;
    logic               is_append;
    logic               empty;
    logic               single;
    logic               scan_more;
    logic               shift_none;
    logic               shift_more;
    logic               out_busy;
    logic [COUNT_W-1:0] count;
  } dp_flags_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_FETCH      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DISPATCH   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CHK_EMPTY  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SCAN_INIT  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SCAN_FIRST = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SCAN       = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SHIFT_INIT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SHIFT      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DONE       = 4'd8;
  localparam logic [STEP_W-1:0] STEP_APPEND     = 4'd9;
  localparam logic [STEP_W-1:0] STEP_EMPTY      = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT       = 4'd11;
  localparam logic [STEP_W-1:0] STEP_RET        = 4'd12;

  // Control store. A taken jump goes to target, otherwise to the next step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_FETCH:      w = '{OP_LATCH,        C_NO_INPUT,   STEP_FETCH};
      STEP_DISPATCH:   w = '{OP_NOP,          C_APPEND,     STEP_APPEND};
      STEP_CHK_EMPTY:  w = '{OP_NOP,          C_EMPTY,      STEP_EMPTY};
      STEP_SCAN_INIT:  w = '{OP_SCAN_INIT,    C_NONE,       STEP_FETCH};
      STEP_SCAN_FIRST: w = '{OP_SCAN_FIRST,   C_SINGLE,     STEP_SHIFT_INIT};
      STEP_SCAN:       w = '{OP_SCAN,         C_SCAN_MORE,  STEP_SCAN};
      STEP_SHIFT_INIT: w = '{OP_SHIFT_INIT,   C_SHIFT_NONE, STEP_DONE};
      STEP_SHIFT:      w = '{OP_SHIFT,        C_SHIFT_MORE, STEP_SHIFT};
      STEP_DONE:       w = '{OP_EXTRACT_DONE, C_ALWAYS,     STEP_EMIT};
      STEP_APPEND:     w = '{OP_APPEND,       C_ALWAYS,     STEP_EMIT};
      STEP_EMPTY:      w = '{OP_SET_EMPTY,    C_NONE,       STEP_FETCH};
      STEP_EMIT:       w = '{OP_EMIT,         C_OUT_BUSY,   STEP_EMIT};
      STEP_RET:        w = '{OP_NOP,          C_ALWAYS,     STEP_FETCH};
      default:         w = '{OP_NOP,          C_ALWAYS,     STEP_FETCH};
    endcase
    return w;
  endfunction

  // Absolute difference of two positions.
  function automatic logic [DIST_W-1:0] pos_dist(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- rtl/core/osenm_sequencer.sv -----
// ----------------------------------------------------------------------------
// osenm_sequencer: microcode step counter
// Holds the step address, reads the control word and resolves jumps.
// ----------------------------------------------------------------------------
module osenm_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  osenm_pkg::dp_flags_t flags,
  output osenm_pkg::ucode_t  uword
);
  import osenm_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take_jump;

  assign uword = ucode_rom(step);

  always_comb begin
    unique case (uword.cond)
      C_NONE:       take_jump = 1'b0;
      C_ALWAYS:     take_jump = 1'b1;
      C_NO_INPUT:   take_jump = !flags.in_valid;
      C_APPEND:     take_jump = flags.is_append;
      C_EMPTY:      take_jump = flags.empty;
      C_SINGLE:     take_jump = flags.single;
      C_SCAN_MORE:  take_jump = flags.scan_more;
      C_SHIFT_NONE: take_jump = flags.shift_none;
      C_SHIFT_MORE: take_jump = flags.shift_more;
      C_OUT_BUSY:   take_jump = flags.out_busy;
      default:      take_jump = 1'b1;
    endcase
    step_next = take_jump ? uword.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- rtl/core/osenm_datapath.sv -----
// ----------------------------------------------------------------------------
// osenm_datapath: entry memory, scan and close-up registers, result register
// Executes one operation per cycle as the control word selects.
// ----------------------------------------------------------------------------
module osenm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  osenm_pkg::ucode_t                 uword,
  input  logic                              s_tvalid,
  input  logic [osenm_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [osenm_pkg::M_TDATA_W-1:0]   m_tdata,
  output osenm_pkg::dp_flags_t              flags
);
  import osenm_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [VALUE_W-1:0] wdata;

  logic               req;
  logic [VALUE_W-1:0] val;
  logic               skip;
  logic [REF_W-1:0]   ref_pos;

  logic [COUNT_W-1:0] count;
  logic [VALUE_W-1:0] best;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   idx;
  logic [STATUS_W-1:0] res_status;
  logic [FOUND_W-1:0]  res_found;

  logic accept;
  logic out_busy;
  logic append_ok;
  logic better;

  assign accept    = s_tvalid && (uword.op == OP_LATCH);
  assign out_busy  = m_tvalid && !m_tready;
  assign append_ok = !skip && (count != COUNT_W'(DEPTH));

  // Nearer-to-reference tie break; the earlier entry keeps equal distances.
  assign better = ($signed(rd_data) < $signed(best)) ||
                  ((rd_data == best) &&
                   (pos_dist(DIST_W'(ref_pos), DIST_W'(idx)) <
                    pos_dist(DIST_W'(pos), DIST_W'(ref_pos))));

  always_comb begin
    flags.in_valid   = s_tvalid;
    flags.is_append  = (req == REQ_APPEND);
    flags.empty      = (count == '0);
    flags.single     = (count == COUNT_W'(1));
    flags.scan_more  = (COUNT_W'(idx) + COUNT_W'(1)) < count;
    flags.shift_none = (COUNT_W'(pos) + COUNT_W'(1)) >= count;
    flags.shift_more = (COUNT_W'(idx) + COUNT_W'(2)) < count;
    flags.out_busy   = out_busy;
    flags.count      = count;
  end

  // Memory port selection.
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    waddr   = count[IDX_W-1:0];
    wdata   = val;
    unique case (uword.op)
      OP_SCAN_FIRST: rd_addr = IDX_W'(1);
      OP_SCAN:       rd_addr = idx + IDX_W'(1);
      OP_SHIFT_INIT: rd_addr = pos + IDX_W'(1);
      OP_SHIFT: begin
        rd_addr = idx + IDX_W'(2);
        we      = 1'b1;
        waddr   = idx;
        wdata   = rd_data;
      end
      OP_APPEND:     we = append_ok;
      default:       rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      val     <= s_tdata[VALUE_W-1:0];
      skip    <= s_tdata[VALUE_W];
      ref_pos <= s_tdata[VALUE_W+REF_W:VALUE_W+1];
      req     <= s_tuser[0];
    end
    unique case (uword.op)
      OP_APPEND: begin
        res_status <= append_ok ? ST_OK : ST_REFUSED;
        res_found  <= '0;
      end
      OP_SET_EMPTY: begin
        res_status <= ST_EMPTY;
        res_found  <= '0;
      end
      OP_SCAN_FIRST: begin
        best <= rd_data;
        pos  <= '0;
        idx  <= IDX_W'(1);
      end
      OP_SCAN: begin
        if (better) begin
          best <= rd_data;
          pos  <= idx;
        end
        idx <= idx + IDX_W'(1);
      end
      OP_SHIFT_INIT: idx <= pos;
      OP_SHIFT:      idx <= idx + IDX_W'(1);
      OP_EXTRACT_DONE: begin
        res_status <= ST_OK;
        res_found  <= FOUND_W'(pos);
      end
      OP_EMIT: begin
        if (!out_busy) begin
          m_tdata <= M_TDATA_W'({res_found, res_status});
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (uword.op == OP_APPEND && append_ok) begin
        count <= count + COUNT_W'(1);
      end else if (uword.op == OP_EXTRACT_DONE) begin
        count <= count - COUNT_W'(1);
      end
      // A new result may replace one that leaves in the same cycle.
      if (uword.op == OP_EMIT && !out_busy) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/ordered_store_extract_nearest_min.sv -----
// ----------------------------------------------------------------------------
// ordered_store_extract_nearest_min: ordered value store with min extraction
// Appends signed values at the tail and removes the smallest one on request,
// breaking ties toward a reference position.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload
//   -------  ---  ------------------------------------------------------------
//   s_*      in   tuser: req_type; tdata: item_value, skip_append, ref_position
//   m_*      out  tdata: status, found_position
//
// An append transaction is accepted in the fetch step, goes through the
// dispatch and append steps and leaves its result in the emit step; the next
// transaction is accepted once the sequencer is back in the fetch step.
// An extract from an empty store goes from the empty check to the emit step.
// An extract from a store of N entries scans all N entries, one per cycle,
// then moves each entry behind the removed one down by one position, one
// entry per cycle with a read and a write in each, to close the gap.
// Reset clears the step counter, the entry count and the result valid flag;
// the memory is not cleared because only positions below the count are used.
// A result waits in the output register while the next transaction is
// accepted; only a second result stalls the sequencer until m_tready.
//
module ordered_store_extract_nearest_min (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Bits from low: item_value[31:0], skip_append[32], ref_position[39:33].
  input  logic [osenm_pkg::S_TDATA_W-1:0] s_tdata,
  // Bits from low: req_type[0].
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Bits from low: status[1:0], found_position[7:2].
  output logic [osenm_pkg::M_TDATA_W-1:0] m_tdata
);
  import osenm_pkg::*;

  ucode_t    uword;
  dp_flags_t flags;

  // The sequencer accepts a new transaction only in its fetch step.
  assign s_tready = (uword.op == OP_LATCH);

  // Step counter and control store.
  osenm_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uword (uword)
  );

  // Entry memory, scan registers and result register.
  osenm_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .uword    (uword),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .flags    (flags)
  );

  // The store never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    flags.count <= COUNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // One transaction at a time: after acceptance the input stays closed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // Only the three defined status codes are ever produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_REFUSED ||
                  m_tdata[1:0] == ST_EMPTY))
    else $error("undefined status code");

  // A refused append or an empty extract reports position zero.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[7:2] == '0))
    else $error("nonzero position with failure status");

endmodule
